>>> hdl/b64c_pkg.sv
package b64c_pkg;

    // Most results that one item can cause: one data character plus a padded tail.
    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int PtrW       = $clog2(MaxResults);

    // ASCII codes used by the alphabet and the padding.
    localparam logic [7:0] CharUpperA = 8'h41;
    localparam logic [7:0] CharUpperZ = 8'h5A;
    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharLowerZ = 8'h7A;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharPlus   = 8'h2B;
    localparam logic [7:0] CharSlash  = 8'h2F;
    localparam logic [7:0] CharPad    = 8'h3D;

    // Sextet boundaries of the alphabet ranges.
    localparam logic [5:0] FirstLower = 6'd26;
    localparam logic [5:0] FirstDigit = 6'd52;
    localparam logic [5:0] SextetPlus = 6'd62;
    localparam logic [5:0] SextetSlash = 6'd63;

    // Codec state shared by both directions.
    typedef struct packed {
        logic [1:0] pos;
        logic [7:0] carry;
        logic       err;
    } t_state;

    // One result item.
    typedef struct packed {
        logic       bad;
        logic [7:0] data;
    } t_result;

    // All results of one item, entry 0 first.
    typedef struct packed {
        t_result [MaxResults-1:0] res;
        logic [CountW-1:0]        count;
    } t_batch;

    // Decoded character: valid flag and 6-bit value.
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // Map a 6-bit value to its alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] w;
        w = {2'b00, s};
        if (s < FirstLower) begin
            return CharUpperA + w;
        end else if (s < FirstDigit) begin
            return CharLowerA + w - {2'b00, FirstLower};
        end else if (s < SextetPlus) begin
            return CharZero + w - {2'b00, FirstDigit};
        end else if (s == SextetPlus) begin
            return CharPlus;
        end else begin
            return CharSlash;
        end
    endfunction

    // Map a character to its 6-bit value; anything outside the alphabet is invalid.
    function automatic t_sextet dec_sextet(input logic [7:0] c);
        t_sextet r;
        r = '0;
        if (c >= CharUpperA && c <= CharUpperZ) begin
            r.valid = 1'b1;
            r.value = 6'(c - CharUpperA);
        end else if (c >= CharLowerA && c <= CharLowerZ) begin
            r.valid = 1'b1;
            r.value = 6'(c - CharLowerA) + FirstLower;
        end else if (c >= CharZero && c <= CharNine) begin
            r.valid = 1'b1;
            r.value = 6'(c - CharZero) + FirstDigit;
        end else if (c == CharPlus) begin
            r.valid = 1'b1;
            r.value = SextetPlus;
        end else if (c == CharSlash) begin
            r.valid = 1'b1;
            r.value = SextetSlash;
        end
        return r;
    endfunction

endpackage

>>> hdl/b64c_step.sv
module b64c_step
    import b64c_pkg::*;
(
    input  t_state     i_state,
    input  logic       i_func,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_next,
    output t_batch     o_batch
);

    // Next state and all results of one item, from the registered item and state.
    always_comb begin
        logic [7:0] mix;
        t_sextet    sx;
        mix     = '0;
        sx      = '0;
        o_next  = i_state;
        o_batch = '0;
        if (!i_func) begin
            // Encode: one or two characters per byte, depending on group position.
            unique case (i_state.pos)
                2'd1: begin
                    mix = i_state.carry | {4'b0000, i_byte[7:4]};
                    o_batch.res[0] = {1'b0, enc_char(mix[5:0])};
                    o_batch.count  = CountW'(1);
                    o_next.pos     = 2'd2;
                    o_next.carry   = {2'b00, i_byte[3:0], 2'b00};
                end
                2'd2: begin
                    mix = i_state.carry | {6'b000000, i_byte[7:6]};
                    o_batch.res[0] = {1'b0, enc_char(mix[5:0])};
                    o_batch.res[1] = {1'b0, enc_char(i_byte[5:0])};
                    o_batch.count  = CountW'(2);
                    o_next.pos     = 2'd0;
                    o_next.carry   = '0;
                end
                default: begin
                    o_batch.res[0] = {1'b0, enc_char(i_byte[7:2])};
                    o_batch.count  = CountW'(1);
                    o_next.pos     = 2'd1;
                    o_next.carry   = {2'b00, i_byte[1:0], 4'b0000};
                end
            endcase
            // Flush a partial group with padding at the end of a message.
            if (i_last) begin
                if (o_next.pos == 2'd1) begin
                    o_batch.res[1] = {1'b0, enc_char(o_next.carry[5:0])};
                    o_batch.res[2] = {1'b0, CharPad};
                    o_batch.res[3] = {1'b0, CharPad};
                    o_batch.count  = CountW'(4);
                end else if (o_next.pos == 2'd2) begin
                    o_batch.res[1] = {1'b0, enc_char(o_next.carry[5:0])};
                    o_batch.res[2] = {1'b0, CharPad};
                    o_batch.count  = CountW'(3);
                end
            end
        end else if (!i_state.err) begin
            // Decode: padding at the second position of a group is an error.
            if (i_byte == CharPad) begin
                if (i_state.pos == 2'd1) begin
                    o_next.err     = 1'b1;
                    o_batch.res[0] = {1'b1, 8'h00};
                    o_batch.count  = CountW'(1);
                end
            end else begin
                sx = dec_sextet(i_byte);
                if (sx.valid) begin
                    unique case (i_state.pos)
                        2'd0: begin
                            o_next.carry = {sx.value, 2'b00};
                            o_next.pos   = 2'd1;
                        end
                        2'd1: begin
                            mix = i_state.carry | {6'b000000, sx.value[5:4]};
                            o_batch.res[0] = {1'b0, mix};
                            o_batch.count  = CountW'(1);
                            o_next.carry   = {sx.value[3:0], 4'b0000};
                            o_next.pos     = 2'd2;
                        end
                        2'd2: begin
                            mix = i_state.carry | {4'b0000, sx.value[5:2]};
                            o_batch.res[0] = {1'b0, mix};
                            o_batch.count  = CountW'(1);
                            o_next.carry   = {sx.value[1:0], 6'b000000};
                            o_next.pos     = 2'd3;
                        end
                        2'd3: begin
                            mix = i_state.carry | {2'b00, sx.value};
                            o_batch.res[0] = {1'b0, mix};
                            o_batch.count  = CountW'(1);
                            o_next.carry   = '0;
                            o_next.pos     = 2'd0;
                        end
                    endcase
                end
            end
        end
        // The end of a message clears the group state in both directions.
        if (i_last) begin
            o_next = '0;
        end
    end

endmodule

>>> hdl/b64c_outbuf.sv
module b64c_outbuf
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_batch     i_batch,
    input  logic       i_tready,
    output logic       o_free,
    output logic       o_tvalid,
    output logic [7:0] o_tdata,
    output logic       o_tuser,
    output logic       o_tlast
);

    t_result [MaxResults-1:0] r_res;
    logic [CountW-1:0]        r_count;
    logic [PtrW-1:0]          r_ptr;

    // A new batch may be loaded when the buffer is empty or its last item leaves now.
    assign o_free = (r_count == '0) || ((r_count == CountW'(1)) && i_tready);

    // Remaining count and read pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else if (i_load) begin
            r_count <= i_batch.count;
            r_ptr   <= '0;
        end else if ((r_count != '0) && i_tready) begin
            r_count <= r_count - CountW'(1);
            r_ptr   <= r_ptr + PtrW'(1);
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

    // Current result on the output side.
    assign o_tvalid = (r_count != '0);
    assign o_tdata  = r_res[r_ptr].data;
    assign o_tuser  = r_res[r_ptr].bad;
    assign o_tlast  = (r_count == CountW'(1));

endmodule

>>> hdl/base64_stream_codec_top.sv
// Streaming Base64 codec with the standard alphabet and '=' padding. Each input item
// carries one byte in s_axis_tdata, the direction in s_axis_tuser (0 encode, 1 decode)
// and the end of a message in s_axis_tlast. Results leave one per cycle on the master
// side while m_axis_tready is high; m_axis_tuser flags misplaced padding in a decode and
// m_axis_tlast marks the last result of each input item. An item is registered, worked
// out combinationally and loaded into a four-entry result buffer once that buffer is
// free, so a result reaches the master side through the input register and then the
// buffer register. The output port sets the pace: an item's results hold the buffer
// until the last of them is taken, while the next item can already wait in the input
// register. Items that cause no result are never loaded into the buffer.
module base64_stream_codec_top
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] func
    input  logic       s_axis_tlast,   // msg_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] bad_input
    output logic       m_axis_tlast    // run_last
);

    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    t_batch     step_batch;
    logic       buf_free;
    logic       consume;
    logic       load;

    // The registered item is used up once the result buffer can take its results.
    assign consume       = r_in_valid && buf_free;
    assign load          = consume && (step_batch.count != '0);
    assign s_axis_tready = !r_in_valid || consume;

    // Input register control and codec state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (consume) begin
                r_state <= n_state;
            end
        end
    end

    // Input item payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Combinational codec step.
    b64c_step u_step (
        .i_state (r_state),
        .i_func  (r_in_func),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_next  (n_state),
        .o_batch (step_batch)
    );

    // Result buffer feeding the output side one item per cycle while m_axis_tready is high.
    b64c_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_batch  (step_batch),
        .i_tready (m_axis_tready),
        .o_free   (buf_free),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

>>> dv/tb_base64_stream_codec_top.sv
module tb_base64_stream_codec_top
    import b64c_pkg::*;
();

    // Direction codes carried in s_axis_tuser.
    localparam logic OpEncode = 1'b0;
    localparam logic OpDecode = 1'b1;

    localparam int IdlePct     = 11;
    localparam int RandomItems = 475;

    // Filler characters that a decoder must skip.
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharLf    = 8'h0A;
    localparam logic [7:0] CharCr    = 8'h0D;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       func;
        logic [7:0] chr;
        logic       last;
    } t_in_item;

    // Directed row: a known count of results with their characters right-justified,
    // or a count of -1 to take the results from the codec model.
    typedef struct packed {
        logic        func;
        logic [7:0]  chr;
        logic        last;
        int          nfix;
        logic [31:0] fixed_chars;
        logic        fixed_bad;
    } t_plan_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tuser  = 1'b0;    // [0] func
    logic       s_axis_tlast  = 1'b0;    // msg_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tuser;            // [0] bad_input
    logic       m_axis_tlast;            // run_last

    // Codec model state.
    logic [1:0] codec_pos   = 2'd0;
    logic [7:0] codec_carry = 8'h00;
    logic       codec_err   = 1'b0;

    t_out_item  step_res[$];
    t_out_item  codec_out_q[$];
    int         sent_items     = 0;
    int         mismatch_count = 0;
    logic       no_idle        = 1'b0;

    t_plan_row plan [25] = '{
        '{OpEncode, 8'h00,   1'b1,  4, "AA==", 1'b0},   // zero byte, two pads
        '{OpEncode, 8'hFF,   1'b1,  4, "/w==", 1'b0},   // all-ones byte
        '{OpEncode, "M",     1'b0,  1, "T",    1'b0},
        '{OpEncode, "a",     1'b0,  1, "W",    1'b0},
        '{OpEncode, "n",     1'b1,  2, "Fu",   1'b0},   // full group, no tail
        '{OpDecode, "A",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, CharPad, 1'b0,  1, 32'h0,  1'b1},   // padding in second slot
        '{OpDecode, "B",     1'b0,  0, 32'h0,  1'b0},   // ignored after the error
        '{OpDecode, CharPad, 1'b1,  0, 32'h0,  1'b0},
        '{OpDecode, CharPad, 1'b0,  0, 32'h0,  1'b0},   // padding in first slot
        '{OpDecode, "+",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, "/",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, CharSpace, 1'b0, 0, 32'h0, 1'b0},
        '{OpDecode, 8'h80,   1'b0,  0, 32'h0,  1'b0},   // high bytes are invalid
        '{OpDecode, 8'hFF,   1'b0,  0, 32'h0,  1'b0},
        '{OpDecode, "9",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, "0",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, "z",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, "a",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, CharPad, 1'b0,  0, 32'h0,  1'b0},   // padding in third slot
        '{OpDecode, "Z",     1'b1, -1, 32'h0,  1'b0},   // partial bits dropped
        '{OpDecode, "Q",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, "Q",     1'b0, -1, 32'h0,  1'b0},
        '{OpDecode, "Q",     1'b0, -1, 32'h0,  1'b0},
        '{OpEncode, 8'h7F,   1'b1,  4, "fw==", 1'b0}    // encode entered at slot three
    };

    base64_stream_codec_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Alphabet character for the low six bits of v.
    function automatic logic [7:0] char_of_sextet(input logic [7:0] v);
        logic [7:0] s;
        s = {2'b00, v[5:0]};
        if (s < 8'(FirstLower)) begin
            return CharUpperA + s;
        end else if (s < 8'(FirstDigit)) begin
            return CharLowerA + (s - 8'(FirstLower));
        end else if (s < 8'(SextetPlus)) begin
            return CharZero + (s - 8'(FirstDigit));
        end else if (s == 8'(SextetPlus)) begin
            return CharPlus;
        end
        return CharSlash;
    endfunction

    // Six-bit value of an alphabet character, or -1 for anything else.
    function automatic int sextet_of_char(input logic [7:0] c);
        if (c >= CharUpperA && c <= CharUpperZ) begin
            return int'(c - CharUpperA);
        end else if (c >= CharLowerA && c <= CharLowerZ) begin
            return int'(c - CharLowerA) + 26;
        end else if (c >= CharZero && c <= CharNine) begin
            return int'(c - CharZero) + 52;
        end else if (c == CharPlus) begin
            return 62;
        end else if (c == CharSlash) begin
            return 63;
        end
        return -1;
    endfunction

    function automatic void add_result(input logic [7:0] d, input logic bad);
        step_res.push_back(t_out_item'{d, bad, 1'b0});
    endfunction

    // Advance the codec model by one item and leave its results in step_res.
    function automatic void run_codec(input logic func, input logic [7:0] b, input logic last);
        int v;
        step_res.delete();
        if (func == OpEncode) begin
            case (codec_pos)
                2'd1: begin
                    add_result(char_of_sextet(codec_carry | (b >> 4)), 1'b0);
                    codec_carry = {2'b00, b[3:0], 2'b00};
                    codec_pos   = 2'd2;
                end
                2'd2: begin
                    add_result(char_of_sextet(codec_carry | (b >> 6)), 1'b0);
                    add_result(char_of_sextet(b), 1'b0);
                    codec_carry = 8'h00;
                    codec_pos   = 2'd0;
                end
                default: begin
                    // Slot three after a direction switch behaves as slot zero.
                    add_result(char_of_sextet(b >> 2), 1'b0);
                    codec_carry = {2'b00, b[1:0], 4'b0000};
                    codec_pos   = 2'd1;
                end
            endcase
            // Flush the partial group with padding.
            if (last && codec_pos == 2'd1) begin
                add_result(char_of_sextet(codec_carry), 1'b0);
                add_result(CharPad, 1'b0);
                add_result(CharPad, 1'b0);
            end else if (last && codec_pos == 2'd2) begin
                add_result(char_of_sextet(codec_carry), 1'b0);
                add_result(CharPad, 1'b0);
            end
        end else if (!codec_err) begin
            if (b == CharPad) begin
                if (codec_pos == 2'd1) begin
                    codec_err = 1'b1;
                    add_result(8'h00, 1'b1);
                end
            end else begin
                v = sextet_of_char(b);
                if (v >= 0) begin
                    case (codec_pos)
                        2'd0: begin
                            codec_carry = 8'(v << 2);
                            codec_pos   = 2'd1;
                        end
                        2'd1: begin
                            add_result(codec_carry | 8'(v >> 4), 1'b0);
                            codec_carry = 8'((v & 15) << 4);
                            codec_pos   = 2'd2;
                        end
                        2'd2: begin
                            add_result(codec_carry | 8'(v >> 2), 1'b0);
                            codec_carry = 8'((v & 3) << 6);
                            codec_pos   = 2'd3;
                        end
                        default: begin
                            add_result(codec_carry | 8'(v), 1'b0);
                            codec_carry = 8'h00;
                            codec_pos   = 2'd0;
                        end
                    endcase
                end
            end
        end
        if (last) begin
            codec_pos   = 2'd0;
            codec_carry = 8'h00;
            codec_err   = 1'b0;
        end
        if (step_res.size() > 0) begin
            step_res[step_res.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Offer one item, wait for acceptance, then queue the results it should cause.
    task automatic send_item(input t_in_item it, input int nfix,
                             input logic [31:0] fixed_chars, input logic fixed_bad);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = it.chr;
        s_axis_tuser  = it.func;
        s_axis_tlast  = it.last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        run_codec(it.func, it.chr, it.last);
        if (nfix < 0) begin
            foreach (step_res[k]) codec_out_q.push_back(step_res[k]);
        end else begin
            for (int k = 0; k < nfix; k++) begin
                codec_out_q.push_back(t_out_item'{fixed_chars[8*(nfix-1-k) +: 8],
                                                  fixed_bad, k == nfix - 1});
            end
        end
        sent_items++;
    endtask

    // A message of raw bytes; now and then a longer one.
    task automatic send_encode_msg();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            send_item(t_in_item'{OpEncode, 8'($urandom_range(0, 255)), k == len - 1},
                      -1, 32'h0, 1'b0);
        end
    endtask

    // A mostly well-formed encoded text, sometimes with filler, stray bytes,
    // missing or misplaced padding.
    task automatic send_decode_msg();
        t_in_item msg_q[$];
        int       nsext;
        int       nfill;
        logic [7:0] c;
        nsext = 4 * $urandom_range(1, 5) - $urandom_range(0, 2);
        for (int k = 0; k < nsext; k++) begin
            msg_q.push_back(t_in_item'{OpDecode, char_of_sextet(8'($urandom_range(0, 63))),
                                       1'b0});
        end
        if ($urandom_range(0, 99) < 85) begin
            while (msg_q.size() % 4 != 0) msg_q.push_back(t_in_item'{OpDecode, CharPad, 1'b0});
        end
        if ($urandom_range(0, 99) < 30) begin
            nfill = $urandom_range(1, 3);
            for (int k = 0; k < nfill; k++) begin
                case ($urandom_range(0, 4))
                    0: c = CharSpace;
                    1: c = CharTab;
                    2: c = CharLf;
                    3: c = CharCr;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                msg_q.insert($urandom_range(0, msg_q.size() - 1), t_in_item'{OpDecode, c, 1'b0});
            end
        end
        if ($urandom_range(0, 99) < 10) begin
            msg_q.insert($urandom_range(0, msg_q.size() - 1),
                         t_in_item'{OpDecode, CharPad, 1'b0});
        end
        msg_q[msg_q.size() - 1].last = 1'b1;
        foreach (msg_q[k]) send_item(msg_q[k], -1, 32'h0, 1'b0);
    endtask

    // Random bytes with a random direction per item, so the direction flips mid-message.
    task automatic send_noise_burst();
        int len;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            send_item(t_in_item'{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 $urandom_range(0, 4) == 0}, -1, 32'h0, 1'b0);
        end
    endtask

    // Result sink with random back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready = no_idle || ($urandom_range(0, 99) >= IdlePct);
    end

    // Compare every accepted result with the oldest expected one.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (codec_out_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result data %02h", m_axis_tdata));
            end else begin
                want = codec_out_q.pop_front();
                if (m_axis_tdata !== want.data) begin
                    note_mismatch($sformatf("data %02h, want %02h", m_axis_tdata, want.data));
                end
                if (m_axis_tuser !== want.bad) begin
                    note_mismatch($sformatf("bad flag %b, want %b", m_axis_tuser, want.bad));
                end
                if (m_axis_tlast !== want.last) begin
                    note_mismatch($sformatf("last flag %b, want %b", m_axis_tlast, want.last));
                end
            end
        end
    end

    initial begin : stimulus
        int pick;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        foreach (plan[r]) begin
            send_item(t_in_item'{plan[r].func, plan[r].chr, plan[r].last},
                      plan[r].nfix, plan[r].fixed_chars, plan[r].fixed_bad);
        end

        // Random messages; one stretch in the middle runs with no idling on either side.
        sent_items = 0;
        while (sent_items < RandomItems) begin
            no_idle = (sent_items >= 200 && sent_items < 300);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_encode_msg();
            end else if (pick < 85) begin
                send_decode_msg();
            end else begin
                send_noise_burst();
            end
        end
        no_idle = 1'b0;
        @(negedge i_clk) s_axis_tvalid = 1'b0;

        while (codec_out_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("base64_stream_codec_top regression: pass");
        end else begin
            $display("base64_stream_codec_top regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("base64_stream_codec_top regression: fail");
        $finish;
    end

endmodule
